### rtl/lfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

   localparam int HEADER_BYTES          = 8;
   localparam int CRC_BYTES             = 2;
   localparam int DEF_MAX_PAYLOAD_BYTES = 502;
   localparam int DEF_MAX_BUFFER_BYTES  = 512;
   localparam int FIFO_DEPTH            = 4;

   // header byte positions
   localparam int POS_MAGIC_FIRST  = 0;
   localparam int POS_MAGIC_SECOND = 1;
   localparam int POS_VERSION      = 2;
   localparam int POS_TYPE         = 3;
   localparam int POS_SEQ_LO       = 4;
   localparam int POS_SEQ_HI       = 5;
   localparam int POS_LEN_LO       = 6;
   localparam int POS_LEN_HI       = 7;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_MAGIC_FIRST      = 2'd0;
   localparam logic [1:0] REG_MAGIC_SECOND     = 2'd1;
   localparam logic [1:0] REG_PROTOCOL_VERSION = 2'd2;
   localparam logic [7:0] RESET_MAGIC_FIRST      = 8'h00;
   localparam logic [7:0] RESET_MAGIC_SECOND     = 8'h00;
   localparam logic [7:0] RESET_PROTOCOL_VERSION = 8'h01;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_FRAME    = 3'd1,
      ST_TOO_LONG    = 3'd2,
      ST_SHORT       = 3'd3,
      ST_BAD_MAGIC   = 3'd4,
      ST_BAD_LENGTH  = 3'd5,
      ST_BAD_CRC     = 3'd6,
      ST_BAD_VERSION = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [8:0] byte_index;
      status_type status;
      logic [7:0] message_type;
      logic [15:0] sequence_res;
      logic [8:0] payload_length;
      logic       end_flag;
   } rsp_type;

   // one queue entry: what one request left to emit
   typedef struct packed {
      logic        has_pay;
      logic [7:0]  pay_byte;
      logic [8:0]  pay_index;
      logic        has_stat;
      status_type  status;
      logic [7:0]  frame_type;
      logic [15:0] seq;
      logic [8:0]  plen;
   } cmd_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/lfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lfd_front #(
   parameter int MAX_PAYLOAD_BYTES = lfd_pkg::DEF_MAX_PAYLOAD_BYTES,
   parameter int MAX_BUFFER_BYTES  = lfd_pkg::DEF_MAX_BUFFER_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lfd_pkg::req_type req_data,
   input  logic [7:0]       magic_first,
   input  logic [7:0]       magic_second,
   input  logic [7:0]       protocol_version,
   input  logic             fifo_full,
   output logic             push_valid,
   output lfd_pkg::cmd_type push_cmd
);
   import lfd_pkg::*;

   localparam int CW = $clog2(MAX_BUFFER_BYTES + 1);
   // wide enough for the count and for header + 16-bit length + crc
   localparam int XW = ((CW > 17) ? CW : 17) + 1;

   logic [CW-1:0] count_ff, count_in, count_upd;
   logic [15:0]   crc_run_ff, crc_run_in, crc_run_upd;
   logic [15:0]   crc_cap_ff, crc_cap_in, crc_cap_upd;
   logic [15:0]   crc_rcv_ff, crc_rcv_in, crc_rcv_upd;
   logic [15:0]   hlen_ff, hlen_in, hlen_upd;
   logic [15:0]   hseq_ff, hseq_in, hseq_upd;
   logic [7:0]    htype_ff, htype_in, htype_upd;
   logic [7:0]    hver_ff, hver_in, hver_upd;
   logic          mm_ff, mm_in, mm_upd;
   logic          nz_ff, nz_in, nz_upd;
   logic          ovf_ff, ovf_in, ovf_upd;

   logic          accept;
   logic          last;
   logic [7:0]    b;
   logic [XW-1:0] p_x;
   logic [XW-1:0] crc_pos;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] total;
   logic          len_ok;
   logic          in_range;
   logic          pay_emit;
   logic          hdr;
   status_type    status;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.data_byte;
   assign last      = req_data.last_byte;

   always_comb begin
      p_x      = XW'(count_ff);
      crc_pos  = XW'(HEADER_BYTES) + XW'(hlen_ff);
      len_ok   = hlen_ff <= 16'(MAX_PAYLOAD_BYTES);
      in_range = count_ff < CW'(MAX_BUFFER_BYTES);
      pay_emit = 1'b0;

      count_upd   = count_ff;
      crc_run_upd = crc_run_ff;
      crc_cap_upd = crc_cap_ff;
      crc_rcv_upd = crc_rcv_ff;
      hlen_upd    = hlen_ff;
      hseq_upd    = hseq_ff;
      htype_upd   = htype_ff;
      hver_upd    = hver_ff;
      mm_upd      = mm_ff;
      nz_upd      = nz_ff | (b != 8'h00);
      ovf_upd     = ovf_ff;

      if (!in_range) begin
         // drop the byte, only remember the overrun
         ovf_upd = 1'b1;
      end else begin
         if (count_ff == CW'(POS_MAGIC_FIRST) && b != magic_first) mm_upd = 1'b1;
         if (count_ff == CW'(POS_MAGIC_SECOND) && b != magic_second) mm_upd = 1'b1;
         if (count_ff == CW'(POS_VERSION)) hver_upd = b;
         if (count_ff == CW'(POS_TYPE)) htype_upd = b;
         if (count_ff == CW'(POS_SEQ_LO)) hseq_upd[7:0] = b;
         if (count_ff == CW'(POS_SEQ_HI)) hseq_upd[15:8] = b;
         if (count_ff == CW'(POS_LEN_LO)) hlen_upd[7:0] = b;
         if (count_ff == CW'(POS_LEN_HI)) hlen_upd[15:8] = b;

         if (p_x >= XW'(HEADER_BYTES)) begin
            if (p_x == crc_pos) begin
               crc_cap_upd      = crc_run_ff;
               crc_rcv_upd[7:0] = b;
            end else if (p_x == crc_pos + XW'(1)) begin
               crc_rcv_upd[15:8] = b;
            end else if (p_x < crc_pos && len_ok && !mm_ff) begin
               pay_emit = 1'b1;
            end
         end
         crc_run_upd = crc16_byte(crc_run_ff, b);
         count_upd   = count_ff + CW'(1);
      end

      cnt_x = XW'(count_upd);
      total = XW'(HEADER_BYTES) + XW'(hlen_upd) + XW'(CRC_BYTES);
      hdr   = !ovf_upd && cnt_x >= XW'(HEADER_BYTES) && !mm_upd;

      if (ovf_upd) status = ST_TOO_LONG;
      else if (cnt_x < XW'(HEADER_BYTES + CRC_BYTES)) status = ST_SHORT;
      else if (mm_upd) status = nz_upd ? ST_BAD_MAGIC : ST_NO_FRAME;
      else if (hlen_upd > 16'(MAX_PAYLOAD_BYTES)) status = ST_BAD_LENGTH;
      else if (cnt_x < total) status = ST_SHORT;
      else if (crc_cap_upd != crc_rcv_upd) status = ST_BAD_CRC;
      else if (hver_upd != protocol_version) status = ST_BAD_VERSION;
      else status = ST_OK;

      push_cmd.has_pay    = pay_emit;
      push_cmd.pay_byte   = b;
      push_cmd.pay_index  = 9'(p_x - XW'(HEADER_BYTES));
      push_cmd.has_stat   = last;
      push_cmd.status     = status;
      push_cmd.frame_type = hdr ? htype_upd : 8'h00;
      push_cmd.seq        = hdr ? hseq_upd : 16'h0000;
      push_cmd.plen       = (status == ST_OK) ? hlen_upd[8:0] : 9'd0;
      push_valid          = accept && (pay_emit || last);

      // end of buffer: return to the idle frame state
      if (last) begin
         count_in   = '0;
         crc_run_in = CRC_INIT;
         crc_cap_in = '0;
         crc_rcv_in = '0;
         hlen_in    = '0;
         hseq_in    = '0;
         htype_in   = '0;
         hver_in    = '0;
         mm_in      = 1'b0;
         nz_in      = 1'b0;
         ovf_in     = 1'b0;
      end else begin
         count_in   = count_upd;
         crc_run_in = crc_run_upd;
         crc_cap_in = crc_cap_upd;
         crc_rcv_in = crc_rcv_upd;
         hlen_in    = hlen_upd;
         hseq_in    = hseq_upd;
         htype_in   = htype_upd;
         hver_in    = hver_upd;
         mm_in      = mm_upd;
         nz_in      = nz_upd;
         ovf_in     = ovf_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_run_ff <= CRC_INIT;
         crc_cap_ff <= '0;
         crc_rcv_ff <= '0;
         hlen_ff    <= '0;
         hseq_ff    <= '0;
         htype_ff   <= '0;
         hver_ff    <= '0;
         mm_ff      <= 1'b0;
         nz_ff      <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (accept) begin
         count_ff   <= count_in;
         crc_run_ff <= crc_run_in;
         crc_cap_ff <= crc_cap_in;
         crc_rcv_ff <= crc_rcv_in;
         hlen_ff    <= hlen_in;
         hseq_ff    <= hseq_in;
         htype_ff   <= htype_in;
         hver_ff    <= hver_in;
         mm_ff      <= mm_in;
         nz_ff      <= nz_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

`default_nettype wire

### rtl/lfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  lfd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output lfd_pkg::cmd_type head_cmd
);
   import lfd_pkg::*;

   localparam int PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int NW  = $clog2(FIFO_DEPTH + 1);

   cmd_type       entries_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = count_ff == NW'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + NW'(1);
      else if (do_pop && !do_push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

### rtl/lfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lfd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  lfd_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lfd_pkg::rsp_type rsp_data
);
   import lfd_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   logic    pay_done_ff, pay_done_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    load;
   logic    pay_first;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      load      = !rsp_valid_ff || !rsp_stall;
      pay_first = head_cmd.has_pay && !pay_done_ff;
      // an entry with both results stays until its status has gone out
      pop       = load && head_valid && (!pay_first || !head_cmd.has_stat);

      rsp_data_in = '0;
      if (pay_first) begin
         rsp_data_in.kind         = KIND_PAYLOAD;
         rsp_data_in.payload_byte = head_cmd.pay_byte;
         rsp_data_in.byte_index   = head_cmd.pay_index;
         rsp_data_in.status       = ST_OK;
      end else begin
         rsp_data_in.kind           = KIND_STATUS;
         rsp_data_in.status         = head_cmd.status;
         rsp_data_in.message_type   = head_cmd.frame_type;
         rsp_data_in.sequence_res   = head_cmd.seq;
         rsp_data_in.payload_length = head_cmd.plen;
         rsp_data_in.end_flag       = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      pay_done_in  = pay_done_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         pay_done_in  = head_valid && pay_first && head_cmd.has_stat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pay_done_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pay_done_ff  <= pay_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### rtl/link_frame_deframer_crc16_unit.sv
// An accepted request's results are written into the queue and then loaded into the output register.
// The front takes one byte per cycle while the queue is not full; a last byte that also carries
// payload gives two results, the payload result and then the status result, from the output register.
// The front parser updates CRC and header state for each accepted byte; a 4-entry queue feeds the back.
// Reset (synchronous, active high) clears all frame state and the queue and sets magic to 0
// and protocol version to 1.
`timescale 1ns / 1ps
`default_nettype none

module link_frame_deframer_crc16_unit #(
   parameter int MAX_PAYLOAD_BYTES = lfd_pkg::DEF_MAX_PAYLOAD_BYTES,
   parameter int MAX_BUFFER_BYTES  = lfd_pkg::DEF_MAX_BUFFER_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lfd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lfd_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lfd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lfd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import lfd_pkg::*;

   logic [7:0] magic_first_ff, magic_first_in;
   logic [7:0] magic_second_ff, magic_second_in;
   logic [7:0] version_ff, version_in;
   logic       csr_write;
   logic [1:0] reg_sel;

   logic    push_valid;
   cmd_type push_cmd;
   logic    fifo_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      magic_first_in  = magic_first_ff;
      magic_second_in = magic_second_ff;
      version_in      = version_ff;
      csr_prdata      = '0;
      case (reg_sel)
         REG_MAGIC_FIRST: begin
            csr_prdata = CSR_DATA_W'(magic_first_ff);
            if (csr_write) magic_first_in = csr_pwdata[7:0];
         end
         REG_MAGIC_SECOND: begin
            csr_prdata = CSR_DATA_W'(magic_second_ff);
            if (csr_write) magic_second_in = csr_pwdata[7:0];
         end
         REG_PROTOCOL_VERSION: begin
            csr_prdata = CSR_DATA_W'(version_ff);
            if (csr_write) version_in = csr_pwdata[7:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= RESET_MAGIC_FIRST;
         magic_second_ff <= RESET_MAGIC_SECOND;
         version_ff      <= RESET_PROTOCOL_VERSION;
      end else begin
         magic_first_ff  <= magic_first_in;
         magic_second_ff <= magic_second_in;
         version_ff      <= version_in;
      end
   end

   lfd_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .magic_first     (magic_first_ff),
      .magic_second    (magic_second_ff),
      .protocol_version(version_ff),
      .fifo_full       (fifo_full),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd)
   );

   lfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   lfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/lfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lfd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lfd_pkg::rsp_type rsp_data
);
   import lfd_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_PAYLOAD |->
         !rsp_data.end_flag && rsp_data.status == ST_OK && rsp_data.payload_length == 9'd0)
      else $error("payload result carries status fields");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |->
         rsp_data.end_flag && rsp_data.payload_byte == 8'h00 && rsp_data.byte_index == 9'd0)
      else $error("status result carries payload fields");

   a_fail_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS && rsp_data.status != ST_OK |->
         rsp_data.payload_length == 9'd0)
      else $error("failed frame reports a length");

endmodule

bind link_frame_deframer_crc16_unit lfd_checker u_lfd_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire
